@@ rtl/core/pdtc_pkg.sv @@
// Shared types, codes and helpers for the percent decoder with display cursor.
// Used by pdtc_decode, pdtc_cursor and percent_decode_text_cursor_top.
`default_nettype none

package pdtc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DECODE = 2'd2;

    localparam int CFG_DATA_W = 7;

    localparam logic [6:0] RST_WIDTH  = 7'd16;
    localparam logic [3:0] RST_HEIGHT = 4'd2;
    localparam logic       RST_DECODE = 1'b1;

    // Input word command codes
    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_CURSOR = 1'b1;

    // Escape phase codes
    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       end_of_message;
        logic [7:0] set_col;
        logic [7:0] set_row;
    } t_item;

    typedef struct packed {
        logic       emit;
        logic [7:0] ch;
    } t_emit;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic       wrap;
    } t_pos;

    // Hex digit value; anything that is not a hex digit counts as 0
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pdtc_decode.sv @@
// Percent/plus decoder with its escape state.
// Depends on pdtc_pkg.
`default_nettype none

module pdtc_decode (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire logic           i_decode_en,
    input  wire pdtc_pkg::t_item i_item,
    output pdtc_pkg::t_emit     o_emit
);

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_hi, n_hi;
    logic [3:0] w_hex;

    assign w_hex = pdtc_pkg::hex_value(i_item.data_byte);

    always_comb begin
        n_phase     = r_phase;
        n_hi        = r_hi;
        o_emit.emit = 1'b0;
        o_emit.ch   = i_item.data_byte;
        if (i_fire) begin
            if (i_item.cmd == pdtc_pkg::CMD_BYTE) begin
                if (!i_decode_en) begin
                    n_phase     = pdtc_pkg::ESC_IDLE;
                    o_emit.emit = 1'b1;
                end else begin
                    unique case (r_phase)
                        pdtc_pkg::ESC_HIGH: begin
                            n_hi    = w_hex;
                            n_phase = pdtc_pkg::ESC_LOW;
                        end
                        pdtc_pkg::ESC_LOW: begin
                            o_emit.emit = 1'b1;
                            o_emit.ch   = {r_hi, w_hex};
                            n_phase     = pdtc_pkg::ESC_IDLE;
                        end
                        default: begin
                            n_phase = pdtc_pkg::ESC_IDLE;
                            if (i_item.data_byte == pdtc_pkg::CH_PERCENT) begin
                                n_phase = pdtc_pkg::ESC_HIGH;
                            end else begin
                                o_emit.emit = 1'b1;
                                if (i_item.data_byte == pdtc_pkg::CH_PLUS) begin
                                    o_emit.ch = pdtc_pkg::CH_SPACE;
                                end
                            end
                        end
                    endcase
                end
            end
            // drop an unfinished escape at the end of a message
            if (i_item.end_of_message) begin
                n_phase = pdtc_pkg::ESC_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pdtc_pkg::ESC_IDLE;
            r_hi    <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_hi    <= n_hi;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pdtc_cursor.sv @@
// Display cursor: position registers, load on command, advance and wrap per character.
// Depends on pdtc_pkg.
`default_nettype none

module pdtc_cursor (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire pdtc_pkg::t_item i_item,
    input  wire logic            i_emit,
    input  wire logic [6:0]      i_width,
    input  wire logic [3:0]      i_height,
    output pdtc_pkg::t_pos       o_pos
);

    logic [7:0] r_col, n_col;
    logic [7:0] r_row, n_row;
    logic [8:0] w_col_inc;
    logic [8:0] w_row_inc;
    logic       w_wrap;

    assign w_col_inc = {1'b0, r_col} + 9'd1;
    assign w_row_inc = {1'b0, r_row} + 9'd1;
    assign w_wrap    = w_col_inc >= {2'b00, i_width};

    // position reported is the one before the advance
    assign o_pos.col  = r_col;
    assign o_pos.row  = r_row;
    assign o_pos.wrap = w_wrap;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_fire && i_item.cmd == pdtc_pkg::CMD_CURSOR) begin
            n_col = i_item.set_col;
            n_row = i_item.set_row;
        end else if (i_emit) begin
            if (w_wrap) begin
                n_col = 8'd0;
                n_row = (w_row_inc >= {5'd0, i_height}) ? 8'd0 : w_row_inc[7:0];
            end else begin
                n_col = w_col_inc[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 8'd0;
            r_row <= 8'd0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/percent_decode_text_cursor_top.sv @@
// Top level: config registers, input word register, result register, assertions.
// Depends on pdtc_pkg, pdtc_decode, pdtc_cursor.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid / o_in_ready, cmd byte eom col row | in
//  out     | o_out_valid / i_out_ready, char col row repos | out
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data           | in
//
// One word per cycle while the result register is free or being drained:
// the decoder and cursor work on the word in the input register, and the
// result register loads at the next edge when a character is emitted.
// The input register takes a new word while a result waits, as long as
// it is empty or its word can move on; a stalled result holds it when full.
// Synchronous active-low reset clears the escape phase, cursor and valids.
`default_nettype none

module percent_decode_text_cursor_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_cmd,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_message,
    input  wire logic [7:0] i_set_col,
    input  wire logic [7:0] i_set_row,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_char,
    output logic [7:0]      o_out_col,
    output logic [7:0]      o_out_row,
    output logic            o_reposition,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [pdtc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [6:0]      r_width;
    logic [3:0]      r_height;
    logic            r_decode;

    logic            r_in_vld;
    pdtc_pkg::t_item r_in;
    logic            w_fire;

    pdtc_pkg::t_emit w_emit;
    pdtc_pkg::t_pos  w_pos;

    logic            r_out_vld;
    logic [7:0]      r_out_char;
    logic [7:0]      r_out_col;
    logic [7:0]      r_out_row;
    logic            r_out_wrap;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pdtc_pkg::RST_WIDTH;
            r_height <= pdtc_pkg::RST_HEIGHT;
            r_decode <= pdtc_pkg::RST_DECODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pdtc_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[6:0];
                pdtc_pkg::CFG_HEIGHT: r_height <= i_cfg_data[3:0];
                pdtc_pkg::CFG_DECODE: r_decode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // word moves on when the result register is free or being drained
    assign w_fire     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.cmd            <= i_cmd;
            r_in.data_byte      <= i_data_byte;
            r_in.end_of_message <= i_end_of_message;
            r_in.set_col        <= i_set_col;
            r_in.set_row        <= i_set_row;
        end
    end

    pdtc_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_decode_en (r_decode),
        .i_item      (r_in),
        .o_emit      (w_emit)
    );

    pdtc_cursor u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_emit   (w_emit.emit),
        .i_width  (r_width),
        .i_height (r_height),
        .o_pos    (w_pos)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.emit) begin
            r_out_char <= w_emit.ch;
            r_out_col  <= w_pos.col;
            r_out_row  <= w_pos.row;
            r_out_wrap <= w_pos.wrap;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_char   = r_out_char;
    assign o_out_col    = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_reposition = r_out_wrap;

`ifndef SYNTHESIS
    a_cursor_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.cmd == pdtc_pkg::CMD_CURSOR)
        |=> (w_pos.col == $past(r_in.set_col) && w_pos.row == $past(r_in.set_row)))
        else $error("cursor not loaded by set command");

    a_wrap_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit.emit && w_pos.wrap) |=> (w_pos.col == 8'd0 && o_reposition))
        else $error("wrap did not return cursor to column zero");

    a_raw_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.cmd == pdtc_pkg::CMD_BYTE && !r_decode)
        |=> (o_out_valid && o_out_char == $past(r_in.data_byte)))
        else $error("raw byte not passed through");
`endif

endmodule

`default_nettype wire
